>>> sv/tmfc_pkg.sv
// Package: message types, frame constants, CRC-16 step and job record for the framer.
package tmfc_pkg;

  // Message type codes carried with each input request
  typedef enum logic [1:0] {
    MSG_CONTROL   = 2'd0,
    MSG_SIGNAL    = 2'd1,
    MSG_AUTOPILOT = 2'd2,
    MSG_UNKNOWN   = 2'd3
  } msg_type_t;

  // Preamble characters
  localparam logic [7:0] MARK_CONTROL   = 8'h24; // '$'
  localparam logic [7:0] MARK_SIGNAL    = 8'h25; // '%'
  localparam logic [7:0] MARK_AUTOPILOT = 8'h5e; // '^'
  localparam logic [7:0] MARK_UNKNOWN   = 8'h61; // 'a'

  // Payload lengths in bytes
  localparam logic [5:0] SIZE_CONTROL   = 6'd32;
  localparam logic [5:0] SIZE_SIGNAL    = 6'd8;
  localparam logic [5:0] SIZE_AUTOPILOT = 6'd24;
  localparam logic [5:0] SIZE_UNKNOWN   = 6'd0;

  // One request's worth of output work, handed from the framer to the emitter
  typedef struct packed {
    logic [7:0]  mark;     // preamble character
    logic [7:0]  pay;      // payload byte
    logic [15:0] crc;      // CRC for the tail bytes
    logic        has_pre;  // starts a frame: preamble and zero byte first
    logic        has_pay;  // carries a payload byte
    logic        has_tail; // closes a frame: CRC low then high byte
  } tmfc_job_t;

  function automatic logic [7:0] mark_of(input msg_type_t t);
    logic [7:0] m;
    unique case (t)
      MSG_CONTROL:   m = MARK_CONTROL;
      MSG_SIGNAL:    m = MARK_SIGNAL;
      MSG_AUTOPILOT: m = MARK_AUTOPILOT;
      default:       m = MARK_UNKNOWN;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] size_of(input msg_type_t t);
    logic [5:0] s;
    unique case (t)
      MSG_CONTROL:   s = SIZE_CONTROL;
      MSG_SIGNAL:    s = SIZE_SIGNAL;
      MSG_AUTOPILOT: s = SIZE_AUTOPILOT;
      default:       s = SIZE_UNKNOWN;
    endcase
    return s;
  endfunction

  // CRC-16, poly 0x1021, one byte in xorshift form
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = {c[7:0], c[15:8]};
    x = x ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

>>> sv/tmfc_emitter.sv
// Emitter: holds one request's job and plays its frame bytes into the output register.
module tmfc_emitter #(
  parameter int PREAMBLE_LEN = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_load,   // request accepted this cycle
  input  tmfc_pkg::tmfc_job_t job_in,
  output logic               job_ready,  // can take a new job this cycle
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] frame_byte
  output logic               m_axis_tuser,  // [0] end_of_frame
  output logic               m_axis_tlast   // last_of_run
);

  localparam int CntW = $clog2(PREAMBLE_LEN + 3);
  localparam logic [CntW-1:0] PreN = CntW'(PREAMBLE_LEN);

  tmfc_pkg::tmfc_job_t job;
  logic            job_valid;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] pre_off;
  logic [CntW-1:0] count;
  logic [CntW-1:0] q;
  logic [CntW-1:0] tail_idx;
  logic            adv;
  logic            last;
  logic [7:0]      res_byte;
  logic            res_eof;

  // Frame layout of the current job
  always_comb begin
    pre_off  = job.has_pre ? PreN : '0;
    count    = pre_off + CntW'(job.has_pay) + (job.has_tail ? CntW'(2) : '0);
    q        = pos - pre_off;
    tail_idx = q - CntW'(job.has_pay);
    last     = (pos == count - CntW'(1));
    adv      = job_valid && (!m_axis_tvalid || m_axis_tready);
    job_ready = !job_valid || (adv && last);
  end

  // Byte at the current position
  always_comb begin
    res_eof = 1'b0;
    priority if (job.has_pre && (pos < PreN - CntW'(1))) begin
      res_byte = job.mark;
    end else if (job.has_pre && (pos == PreN - CntW'(1))) begin
      res_byte = 8'h00;
    end else if (job.has_pay && (q == '0)) begin
      res_byte = job.pay;
    end else if (tail_idx == '0) begin
      res_byte = job.crc[7:0];
    end else begin
      res_byte = job.crc[15:8];
      res_eof  = 1'b1;
    end
  end

  // Job register and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pos       <= '0;
    end else if (job_load) begin
      job_valid <= 1'b1;
      pos       <= '0;
    end else if (adv && last) begin
      job_valid <= 1'b0;
    end else if (adv) begin
      pos <= pos + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_eof;
      m_axis_tlast <= last;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (pos < count))
    else $error("emitter position past end of job");
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end of frame not on last byte of request");
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    job_load |=> (job_valid && (pos == '0)))
    else $error("job load did not start at position zero");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> job_ready)
    else $error("emitter idle but not ready");
`endif

endmodule

>>> sv/typed_message_framer_crc16_top.sv
// Top level: typed message framer with CRC-16 (poly 0x1021, init 0).
//
// Input stream s_axis: one payload byte per request, tagged in tuser with the
// message type (0 control, 1 signal, 2 autopilot, 3 unknown). The type is only
// looked at on the first byte of a message.
// Output stream m_axis: one wire byte per transfer; tuser marks the CRC high
// byte (end of frame), tlast marks the last byte caused by one input request.
//
// A first byte yields PREAMBLE_LEN preamble bytes plus the byte itself; a
// middle byte yields one output byte; the last byte of a payload yields three
// (byte, CRC low, CRC high). An unknown type yields preamble plus two zero CRC
// bytes and its data byte is dropped.
// An accepted input is held in the emitter's job register, and from there its
// bytes enter the output register. The emitter produces one output byte per
// cycle while the receiver does not stall. A new input is taken in the
// same cycle the previous request's last byte enters the output register.
// Reset clears the framer to idle with the CRC at zero. When the receiver
// stalls, the output register holds, and s_axis_tready stays low while the
// emitter holds a job that cannot advance.
module typed_message_framer_crc16_top #(
  parameter int PREAMBLE_LEN = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] msg_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] frame_byte
  output logic       m_axis_tuser,   // [0] end_of_frame
  output logic       m_axis_tlast    // last_of_run
);

  logic        in_message;
  logic        in_message_next;
  logic [5:0]  bytes_left;
  logic [5:0]  bytes_left_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_upd;
  logic        accept;
  tmfc_pkg::msg_type_t in_type;
  tmfc_pkg::tmfc_job_t job_new;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_type = tmfc_pkg::msg_type_t'(s_axis_tuser);

  // Frame state update and job for this request
  always_comb begin
    job_new.mark     = tmfc_pkg::mark_of(in_type);
    job_new.pay      = s_axis_tdata;
    job_new.has_pre  = !in_message;
    job_new.has_pay  = 1'b1;
    job_new.has_tail = 1'b0;
    crc_upd          = tmfc_pkg::crc_byte(in_message ? crc : 16'h0000, s_axis_tdata);
    job_new.crc      = crc_upd;
    in_message_next  = 1'b1;
    crc_next         = crc_upd;
    bytes_left_next  = bytes_left;
    if (in_message) begin
      if (bytes_left != 6'd0) begin
        bytes_left_next = bytes_left - 6'd1;
      end
      if (bytes_left_next == 6'd0) begin
        job_new.has_tail = 1'b1;
        in_message_next  = 1'b0;
        crc_next         = 16'h0000;
      end
    end else if (in_type == tmfc_pkg::MSG_UNKNOWN) begin
      job_new.has_pay  = 1'b0;
      job_new.has_tail = 1'b1;
      job_new.crc      = 16'h0000;
      in_message_next  = 1'b0;
      crc_next         = 16'h0000;
      bytes_left_next  = tmfc_pkg::SIZE_UNKNOWN;
    end else begin
      // No payload is shorter than 8 bytes, so the first byte never closes it
      bytes_left_next = tmfc_pkg::size_of(in_type) - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      bytes_left <= 6'd0;
      crc        <= 16'h0000;
    end else if (accept) begin
      in_message <= in_message_next;
      bytes_left <= bytes_left_next;
      crc        <= crc_next;
    end
  end

  tmfc_emitter #(
    .PREAMBLE_LEN (PREAMBLE_LEN)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .job_load      (accept),
    .job_in        (job_new),
    .job_ready     (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_unknown_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_message && (in_type == tmfc_pkg::MSG_UNKNOWN)) |=> !in_message)
    else $error("unknown type opened a message");
  a_known_opens: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_message && (in_type != tmfc_pkg::MSG_UNKNOWN)) |=>
      (in_message && (bytes_left != 6'd0)))
    else $error("known type did not open a message");
  a_idle_crc_zero: assert property (@(posedge clk) disable iff (rst)
    !in_message |-> (crc == 16'h0000))
    else $error("CRC not cleared between frames");
`endif

endmodule
